/* src/mmio_pkg.sv */
`timescale 1ns / 1ps

package mmio_pkg;

    // default size of the byte store, as address bits
    localparam int ADDR_BITS_DEF = 16;

    // i/o window and device addresses
    localparam logic [15:0] IO_FIRST   = 16'hF000;
    localparam logic [15:0] IO_LAST    = 16'hF0FF;
    localparam logic [15:0] OUT_PORT   = 16'hF000;
    localparam logic [15:0] IN_PORT    = 16'hF001;
    localparam logic [15:0] TIMER_ADDR = 16'hF010;
    localparam logic [15:0] TIMER_CTL  = 16'hF011;

    // request commands
    typedef enum logic [2:0] {
        CMD_RD_BYTE = 3'd0,
        CMD_WR_BYTE = 3'd1,
        CMD_RD_WORD = 3'd2,
        CMD_WR_WORD = 3'd3,
        CMD_TICK    = 3'd4
    } cmd_t;

    // response kinds
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_TRACE = 2'd2,
        KIND_ACK   = 2'd3
    } kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_wr;   // write zero at the clear pointer
        logic capture;  // latch request word and read its first byte
        logic save_lo;  // keep low byte of a word read
        logic rd_next;  // read the byte at address plus one
        logic act;      // perform the byte action and load the response
        logic sel_hi;   // act on the second byte of a word
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last; // clear pointer at the last entry
        logic out_free; // response register can take a word
        logic rd_word;  // current request is a word read
        logic wr_word;  // current request is a word write
    } sts_t;

endpackage

/* src/mmio_req_if.sv */
`timescale 1ns / 1ps

interface mmio_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [7:0]  input_char;

    modport source (
        output valid, cmd, address, write_data, input_char,
        input  ready
    );

    modport sink (
        input  valid, cmd, address, write_data, input_char,
        output ready
    );
endinterface

/* src/mmio_rsp_if.sv */
`timescale 1ns / 1ps

interface mmio_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] read_data;
    logic [15:0] byte_addr;
    logic [7:0]  old_byte;
    logic [7:0]  new_byte;
    logic        last;

    modport source (
        output valid, kind, read_data, byte_addr, old_byte, new_byte, last,
        input  ready
    );

    modport sink (
        input  valid, kind, read_data, byte_addr, old_byte, new_byte, last,
        output ready
    );
endinterface

/* src/mmio_ram.sv */
`timescale 1ns / 1ps

module mmio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/mmio_ctrl.sv */
`timescale 1ns / 1ps

module mmio_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  mmio_pkg::sts_t sts,
    output logic          in_ready,
    output mmio_pkg::ctl_t ctl
);
    import mmio_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_FIRST  = 4'b0100,
        S_SECOND = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (sts.rd_word)
                begin
                    // low byte kept, fetch the high byte
                    ctl.save_lo = 1'b1;
                    ctl.rd_next = 1'b1;
                    state_next  = S_SECOND;
                end
                else if (sts.out_free)
                begin
                    ctl.act = 1'b1;
                    if (sts.wr_word)
                    begin
                        ctl.rd_next = 1'b1;
                        state_next  = S_SECOND;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SECOND:
            begin
                if (sts.out_free)
                begin
                    ctl.act    = 1'b1;
                    ctl.sel_hi = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/mmio_dp.sv */
`timescale 1ns / 1ps

module mmio_dp #(
    parameter int ADDR_BITS = mmio_pkg::ADDR_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mmio_pkg::ctl_t ctl,
    output mmio_pkg::sts_t sts,
    input  logic [2:0]     cmd,
    input  logic [15:0]    address,
    input  logic [15:0]    write_data,
    input  logic [7:0]     input_char,
    mmio_rsp_if.source     rsp
);
    import mmio_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    // request word
    cmd_t                 op_reg;
    logic [ADDR_BITS-1:0] a_reg;
    logic [15:0]          wd_reg;
    logic [7:0]           ic_reg;
    logic [7:0]           lo_reg;

    // devices and clear pointer
    logic [15:0]          timer_cnt_reg;
    logic [15:0]          timer_cnt_next;
    logic                 timer_on_reg;
    logic                 timer_on_next;
    logic [ADDR_BITS-1:0] clr_cnt_reg;

    // response register
    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [15:0]          out_rd_reg;
    logic [15:0]          out_ba_reg;
    logic [7:0]           out_old_reg;
    logic [7:0]           out_new_reg;
    logic                 out_last_reg;

    logic [ADDR_BITS-1:0] a_plus;
    logic [ADDR_BITS-1:0] ba;
    logic [15:0]          ba16;
    logic                 win;
    logic                 is_wr;
    logic                 to_store;
    logic [7:0]           byte_val;
    logic [7:0]           ram_rdata;
    logic [7:0]           rd_byte;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [7:0]           ram_wdata;
    logic                 ram_re;
    logic [ADDR_BITS-1:0] ram_raddr;

    kind_t                res_kind;
    logic [15:0]          res_rd;
    logic [15:0]          res_ba;
    logic [7:0]           res_old;
    logic [7:0]           res_new;
    logic                 res_last;

    // byte address and window decode
    assign a_plus   = a_reg + ADDR_BITS'(1);
    assign ba       = ctl.sel_hi ? a_plus : a_reg;
    assign ba16     = 16'(ba);
    assign win      = (ba16 >= IO_FIRST) && (ba16 <= IO_LAST);
    assign byte_val = ctl.sel_hi ? wd_reg[15:8] : wd_reg[7:0];
    assign is_wr    = (op_reg == CMD_WR_BYTE) || (op_reg == CMD_WR_WORD);
    assign to_store = !(win && ((ba16 == OUT_PORT) || (ba16 == TIMER_CTL)));

    // read mux over devices and store
    always_comb
    begin
        rd_byte = ram_rdata;
        if (win && (ba16 == IN_PORT))
        begin
            rd_byte = ic_reg;
        end
        else if (win && (ba16 == TIMER_ADDR))
        begin
            rd_byte = timer_cnt_reg[7:0];
        end
        else if (win && (ba16 == TIMER_CTL))
        begin
            rd_byte = timer_cnt_reg[15:8];
        end
    end

    // response word for the current byte
    always_comb
    begin
        res_kind = KIND_ACK;
        res_rd   = '0;
        res_ba   = '0;
        res_old  = '0;
        res_new  = '0;
        res_last = !((op_reg == CMD_WR_WORD) && !ctl.sel_hi);
        case (op_reg)
            CMD_RD_BYTE:
            begin
                res_kind = KIND_READ;
                res_rd   = {8'h00, rd_byte};
            end
            CMD_RD_WORD:
            begin
                res_kind = KIND_READ;
                res_rd   = {rd_byte, lo_reg};
            end
            CMD_WR_BYTE, CMD_WR_WORD:
            begin
                if (win && (ba16 == OUT_PORT))
                begin
                    res_kind = KIND_CHAR;
                    res_ba   = ba16;
                    res_new  = byte_val;
                end
                else if (!win)
                begin
                    res_kind = KIND_TRACE;
                    res_ba   = ba16;
                    res_old  = ram_rdata;
                    res_new  = byte_val;
                end
            end
            default:
            begin
                res_kind = KIND_ACK;
            end
        endcase
    end

    // timer control and tick
    always_comb
    begin
        timer_cnt_next = timer_cnt_reg;
        timer_on_next  = timer_on_reg;
        if (ctl.act && is_wr && win && (ba16 == TIMER_CTL))
        begin
            timer_on_next = |byte_val;
            if (byte_val == 8'h00)
            begin
                timer_cnt_next = '0;
            end
        end
        else if (ctl.act && (op_reg == CMD_TICK) && timer_on_reg)
        begin
            timer_cnt_next = timer_cnt_reg + 16'd1;
        end
    end

    // store ports
    assign ram_we    = ctl.clr_wr || (ctl.act && is_wr && to_store);
    assign ram_waddr = ctl.clr_wr ? clr_cnt_reg : ba;
    assign ram_wdata = ctl.clr_wr ? 8'h00 : byte_val;
    assign ram_re    = ctl.capture || ctl.rd_next;
    assign ram_raddr = ctl.capture ? address[ADDR_BITS-1:0] : a_plus;

    mmio_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_cnt_reg <= '0;
            timer_on_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            timer_cnt_reg <= timer_cnt_next;
            timer_on_reg  <= timer_on_next;
            if (ctl.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
            end
            if (ctl.act)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg <= cmd_t'(cmd);
            a_reg  <= address[ADDR_BITS-1:0];
            wd_reg <= write_data;
            ic_reg <= input_char;
        end
        if (ctl.save_lo)
        begin
            lo_reg <= rd_byte;
        end
        if (ctl.act)
        begin
            out_kind_reg <= res_kind;
            out_rd_reg   <= res_rd;
            out_ba_reg   <= res_ba;
            out_old_reg  <= res_old;
            out_new_reg  <= res_new;
            out_last_reg <= res_last;
        end
    end

    // status
    assign sts.clr_last = &clr_cnt_reg;
    assign sts.out_free = !out_valid_reg || rsp.ready;
    assign sts.rd_word  = (op_reg == CMD_RD_WORD);
    assign sts.wr_word  = (op_reg == CMD_WR_WORD);

    // response port
    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.read_data = out_rd_reg;
    assign rsp.byte_addr = out_ba_reg;
    assign rsp.old_byte  = out_old_reg;
    assign rsp.new_byte  = out_new_reg;
    assign rsp.last      = out_last_reg;

endmodule

/* src/memory_with_mapped_io_timer.sv */
`timescale 1ns / 1ps

// channel | dir | word
// --------+-----+--------------------------------------------------------
// req     | in  | cmd, address, write_data, input_char
// rsp     | out | kind, read_data, byte_addr, old_byte, new_byte, last
//
// a byte read, byte write or tick is captured into S_FIRST, loads its
// response there and returns to S_IDLE for the next request; word reads and
// word writes also pass through S_SECOND, as the byte-wide store with one write
// and one registered read port handles one byte a cycle, unless held by a full
// response register. after reset the store is cleared one byte a cycle, all
// 2**ADDR_BITS bytes (65536 at the default), while req.ready stays low.
// a full response register waits on rsp.ready; a request already taken
// holds in place until its response can be loaded.

module memory_with_mapped_io_timer #(
    parameter int ADDR_BITS = mmio_pkg::ADDR_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mmio_req_if.sink   req,
    mmio_rsp_if.source rsp
);
    import mmio_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;

    // sequencer
    mmio_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .sts      (sts),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    // store, devices and response register
    mmio_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cmd        (req.cmd),
        .address    (req.address),
        .write_data (req.write_data),
        .input_char (req.input_char),
        .rsp        (rsp)
    );

`ifndef SYNTHESIS
    // no request taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr_wr |-> !req.ready)
        else $error("request accepted during store clear");

    // a response is loaded only into a free register
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.act |-> sts.out_free)
        else $error("response register overwritten");

    // sequencer issues at most one of clear, capture, save low and act per cycle
    a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.clr_wr, ctl.capture, ctl.save_lo, ctl.act}))
        else $error("conflicting sequencer steps");

    // a loaded response is offered in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.act |=> rsp.valid)
        else $error("loaded response not presented");
`endif

endmodule
